// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file ifr_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define IFR_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IFR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ifr_pkg.sv
// Shared constants and types of the i-bus frame receiver.
// No dependencies.
package ifr_pkg;

    localparam int FRAME_BYTES   = 32;
    localparam int NUM_CHANNELS  = 14;
    localparam int PAYLOAD_BYTES = 2 * NUM_CHANNELS;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int CNT_W         = $clog2(FRAME_BYTES + 1);
    localparam int MASK_W        = 14;
    localparam int CH_W          = 4;
    localparam int VALUE_W       = 16;
    localparam int OUT_DATA_W    = 24;

    localparam logic [7:0]        HDR_FIRST  = 8'(FRAME_BYTES);
    localparam logic [7:0]        HDR_SECOND = 8'h40;
    localparam logic [15:0]       CSUM_INIT  = 16'hFFFF;
    localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};

    // Frame found on the byte just taken, with its channel bytes.
    typedef struct packed {
        logic                 hit;
        logic [PAYLOAD_W-1:0] payload;
    } frame_evt_t;

endpackage

// File: hw/rtl/ibus_frame_receiver.sv
// Top level of the i-bus frame receiver.
// Depends on ifr_pkg, ifr_window and ifr_emitter.
//
// Usage:
//   s_axis carries received serial bytes, one byte per transaction.
//   Every byte shifts a 32-byte window; the window is a frame when it starts
//   0x20 0x40 and its last two bytes (little-endian) equal 0xFFFF minus the
//   16-bit sum of the other 30 bytes. On a frame, the window is cleared and
//   one m_axis transaction goes out per channel enabled in cfg_wdata's mask,
//   lowest channel first; tlast marks the highest enabled channel.
//   cfg_we writes the 14-bit channel mask (reset: all channels enabled).
// Timing:
//   A byte is taken every cycle while s_axis_tready is high. The byte that
//   completes a frame loads the emitter's pending channels; they reach m_axis
//   through the output register, one channel per cycle while m_axis_tready
//   is high, up to 14 channels a frame, all through the single output register.
//   s_axis_tready drops only when the emitter still holds channels and the
//   next byte could complete another frame (31 or more bytes since the last
//   clear), so a slow or stalled receiver holds the input only in that case.
// Reset:
//   Asynchronous, active low. Window and checksum clear to zero, output
//   register empties, mask returns to all ones.
module ibus_frame_receiver
    import ifr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [MASK_W-1:0]     cfg_wdata,      // channel_enable_mask
    // byte input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    // channel output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] channel_index, [19:4] channel_value
    output logic                  m_axis_tlast    // last_of_frame
);

    logic [MASK_W-1:0] mask_reg;
    logic              accept;
    logic              near_full;
    logic              busy;
    frame_evt_t        evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // a new frame can not be found while the previous one still has channels pending
    assign s_axis_tready = !(busy && near_full);
    assign accept        = s_axis_tvalid && s_axis_tready;

    ifr_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (s_axis_tdata),
        .evt       (evt),
        .near_full (near_full)
    );

    ifr_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .mask     (mask_reg),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .busy     (busy)
    );

endmodule

// File: hw/rtl/ifr_window.sv
// Byte window with running checksum and frame detection.
// Depends on ifr_pkg.
module ifr_window
    import ifr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output frame_evt_t evt,
    output logic       near_full
);

    logic [7:0]       win_reg [FRAME_BYTES];
    logic [15:0]      sum_reg;
    logic [15:0]      sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      csum;
    logic             match;

    // sum_reg tracks bytes 0..FRAME_BYTES-3 of the window
    assign sum_next = sum_reg - 16'(win_reg[0]) + 16'(win_reg[FRAME_BYTES-2]);
    assign csum     = CSUM_INIT - sum_next;
    assign match    = (win_reg[1] == HDR_FIRST) && (win_reg[2] == HDR_SECOND)
                   && (csum == {rx_byte, win_reg[FRAME_BYTES-1]});

    always_comb
    begin
        evt.hit = accept && match;
        for (int j = 0; j < PAYLOAD_BYTES; j++)
        begin
            evt.payload[8*j +: 8] = win_reg[j+3];
        end
    end

    // a hit needs FRAME_BYTES bytes since the last clear
    assign near_full = (cnt_reg >= CNT_W'(FRAME_BYTES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (match)
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    win_reg[i] <= '0;
                end
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < FRAME_BYTES - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[FRAME_BYTES-1] <= rx_byte;
                sum_reg <= sum_next;
                if (cnt_reg != CNT_W'(FRAME_BYTES))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/ifr_emitter.sv
// Channel emitter: walks enabled channels of a captured frame into an output register.
// Depends on ifr_pkg.
module ifr_emitter
    import ifr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  frame_evt_t            evt,
    input  logic [MASK_W-1:0]     mask,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  busy
);

    logic [NUM_CHANNELS-1:0] pending_reg;
    logic [NUM_CHANNELS-1:0] pending_rest;
    logic [PAYLOAD_W-1:0]    payload_reg;
    logic                    out_valid_reg;
    logic [CH_W-1:0]         out_idx_reg;
    logic [VALUE_W-1:0]      out_val_reg;
    logic                    out_last_reg;
    logic [CH_W-1:0]         sel;
    logic                    advance;

    // lowest pending channel
    always_comb
    begin
        sel = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                sel = CH_W'(i);
            end
        end
    end

    assign pending_rest = pending_reg & (pending_reg - 1'b1);
    assign busy         = (pending_reg != '0);
    assign advance      = busy && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.hit)
            begin
                pending_reg <= mask[NUM_CHANNELS-1:0];
            end
            else if (advance)
            begin
                pending_reg <= pending_rest;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.hit)
        begin
            payload_reg <= evt.payload;
        end
        if (advance)
        begin
            out_idx_reg  <= sel;
            out_val_reg  <= payload_reg[VALUE_W*sel +: VALUE_W];
            out_last_reg <= (pending_rest == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - VALUE_W - CH_W)'(0), out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/ifr_checker.sv
// Port-level checks of the i-bus frame receiver, bound to the top level.
// Depends on ifr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ifr_checker
    import ifr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic out_xfer;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    `IFR_ASSERT(a_index_range, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[CH_W-1:0] < CH_W'(NUM_CHANNELS)), "channel index out of range")
    `IFR_ASSERT(a_pad_zero, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:VALUE_W+CH_W] == '0), "tdata pad bits not zero")
    `IFR_ASSERT(a_frame_continues, clk, rst_n, (out_xfer && !m_axis_tlast) |=> m_axis_tvalid, "frame stopped before tlast")
    `IFR_ASSERT(a_index_rises, clk, rst_n, (out_xfer && !m_axis_tlast) |=> (m_axis_tdata[CH_W-1:0] > $past(m_axis_tdata[CH_W-1:0])), "channel order not ascending")
    `IFR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_axis_tvalid, "output valid during reset")

endmodule

bind ibus_frame_receiver ifr_checker u_ifr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/ibus_frame_receiver_tb.sv
// Self-checking testbench for ibus_frame_receiver: byte stream in, channel words out.
// Depends on ifr_pkg and the ibus_frame_receiver RTL; needs no files or arguments.
module ibus_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ifr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;     // closing byte loads pending, then output reg
    localparam int STALL_LIMIT  = 2000;  // cycles without any transaction before giving up
    localparam int RANDOM_BYTES = 16;

    // pacing styles for either side of the block
    typedef enum int {GAP_NONE, GAP_MIXED, GAP_SLOW} gap_mode_e;

    // payload fill used when building a frame
    typedef enum int {PL_RANDOM, PL_ZERO, PL_ONES, PL_RAMP} payload_kind_e;

    // one frame as sent on the wire, byte i in f[i]
    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    // one channel transaction as it should leave the block
    typedef struct packed {
        logic [CH_W-1:0]    ch_idx;
        logic [VALUE_W-1:0] ch_val;
        logic               is_last;
    } chan_word_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [MASK_W-1:0]     cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // shadow state of the receiver: byte window and channel mask
    logic [7:0]        rx_window [FRAME_BYTES] = '{default: 8'h00};
    logic [MASK_W-1:0] enable_mask = MASK_RESET;

    // channel words still owed by the block, oldest first
    chan_word_t chan_expect_q [$];

    int        err_count   = 0;
    int        bytes_sent  = 0;
    int        idle_cycles = 0;
    gap_mode_e src_mode    = GAP_MIXED;
    gap_mode_e snk_mode    = GAP_MIXED;

    ibus_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Frame tracking. Called once per accepted byte: shift the window,
    // test header and checksum, and on a hit queue one word per enabled
    // channel (lowest first, last flag on the highest), then clear.
    // ------------------------------------------------------------------
    function automatic void track_rx_byte(input logic [7:0] b);
        logic [15:0] acc;
        int          top;
        chan_word_t  w;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            rx_window[i] = rx_window[i + 1];
        rx_window[FRAME_BYTES - 1] = b;

        if (rx_window[0] != HDR_FIRST || rx_window[1] != HDR_SECOND)
            return;
        acc = CSUM_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            acc = acc - 16'(rx_window[i]);
        if (acc != {rx_window[FRAME_BYTES - 1], rx_window[FRAME_BYTES - 2]})
            return;

        top = -1;
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (enable_mask[c])
                top = c;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (enable_mask[c])
            begin
                w.ch_idx  = CH_W'(c);
                w.ch_val  = {rx_window[3 + 2 * c], rx_window[2 + 2 * c]};
                w.is_last = (c == top);
                chan_expect_q.push_back(w);
            end
        end
        // a hit empties the window, even with no channel enabled
        foreach (rx_window[i])
            rx_window[i] = 8'h00;
    endfunction

    // Gap per transaction: NONE none, MIXED mostly none/short, some long, SLOW half long.
    function automatic int pick_gap(input gap_mode_e mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == GAP_NONE)
            return 0;
        if (mode == GAP_SLOW)
            return (r < 50) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Checksum over bytes 0..29 into bytes 30 (low) and 31 (high).
    function automatic frame_t seal_frame(input frame_t f);
        logic [15:0] acc;
        acc = CSUM_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            acc = acc - 16'(f[i]);
        f[FRAME_BYTES - 2] = acc[7:0];
        f[FRAME_BYTES - 1] = acc[15:8];
        return f;
    endfunction

    function automatic frame_t make_frame(input payload_kind_e kind);
        frame_t f;
        f    = '0;
        f[0] = HDR_FIRST;
        f[1] = HDR_SECOND;
        for (int i = 2; i < FRAME_BYTES - 2; i++)
        begin
            case (kind)
                PL_ZERO: f[i] = 8'h00;
                PL_ONES: f[i] = 8'hFF;
                PL_RAMP: f[i] = 8'(i);   // every channel byte distinct
                default: f[i] = 8'($urandom);
            endcase
        end
        return seal_frame(f);
    endfunction

    // Line noise, biased toward header lookalikes.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return HDR_FIRST;
            1:       return HDR_SECOND;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(0, 4))
            0:       return MASK_RESET;
            1:       return '0;
            2:       return MASK_W'(1) << $urandom_range(0, NUM_CHANNELS - 1);
            default: return MASK_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte source. tvalid is only lowered when a gap follows, so a
    // back-to-back byte never sees a low and a high in the same step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(src_mode);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_t f);
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(f[i]);
    endtask

    // Stop the source, let every owed channel word come out, then let the
    // pipeline settle (a byte that makes no word may still be in flight).
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (chan_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mask writes only happen with the block idle.
    task automatic write_mask(input logic [MASK_W-1:0] m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we      <= 1'b0;
        enable_mask  = m;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Mask out of reset enables all channels; all-ones payload.
    task automatic test_reset_mask();
        send_frame(make_frame(PL_ONES));
    endtask

    // Single lowest channel, then an alternating pattern up to the highest.
    task automatic test_channel_masks();
        logic [MASK_W-1:0] masks [2];
        masks[0] = 14'h0001;
        masks[1] = 14'h2AAA;
        foreach (masks[i])
        begin
            write_mask(masks[i]);
            send_frame(make_frame(PL_RAMP));
        end
    endtask

    // A frame whose channel 0 bytes look like a header, followed by the two
    // bytes that would make the window shifted by two a valid frame. That
    // second hit must not happen since the first one empties the window.
    // Run once with no channel enabled and once with all of them.
    task automatic test_window_clear();
        frame_t      f;
        logic [15:0] acc;
        for (int pass = 0; pass < 2; pass++)
        begin
            write_mask(pass == 0 ? '0 : MASK_RESET);
            f    = make_frame(PL_RANDOM);
            f[2] = HDR_FIRST;
            f[3] = HDR_SECOND;
            f    = seal_frame(f);
            send_frame(f);
            acc = CSUM_INIT;
            for (int i = 2; i < FRAME_BYTES; i++)
                acc = acc - 16'(f[i]);
            send_byte(acc[7:0]);
            send_byte(acc[15:8]);
        end
    endtask

    // Bad first header byte and bad checksum.
    task automatic test_rejected_windows();
        frame_t f;
        f    = make_frame(PL_RANDOM);
        f[0] = HDR_FIRST ^ 8'h01;
        send_frame(f);
        f     = make_frame(PL_RANDOM);
        f[30] = f[30] ^ 8'h01;
        send_frame(f);
    endtask

    // Full-rate bytes into a slow receiver: back-to-back frames can make the
    // input hold while the previous frame's channels drain.
    task automatic test_backpressure();
        src_mode = GAP_NONE;
        snk_mode = GAP_SLOW;
        repeat (2) send_frame(make_frame(PL_RANDOM));
        src_mode = GAP_MIXED;
        snk_mode = GAP_MIXED;
    endtask

    // One frame with random payload, one time in five with one byte broken,
    // after line noise; pacing and mask change one time in six before it.
    task automatic test_random_traffic();
        int     first;
        int     pick;
        int     pos;
        frame_t f;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                src_mode = gap_mode_e'($urandom_range(0, 2));
                snk_mode = gap_mode_e'($urandom_range(0, 2));
                write_mask(random_mask());
            end
            pick = $urandom_range(0, 99);
            repeat ($urandom_range(0, 3)) send_byte(noise_byte());
            if (pick >= 90)
                repeat ($urandom_range(4, 12)) send_byte(noise_byte());
            f = make_frame(PL_RANDOM);
            if (pick < 20)
            begin
                pos    = $urandom_range(0, FRAME_BYTES - 1);
                f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
            end
            send_frame(f);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver pacing: tready low for a random gap, then high for a while.
    // ------------------------------------------------------------------
    initial
    begin : sink_pacing
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = pick_gap(snk_mode);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Channel checker: every accepted output transaction against the
    // oldest owed word, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : chan_checker
        chan_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (chan_expect_q.size() == 0)
            begin
                $display("%0t: unexpected channel transaction, index %0d value %h last %b",
                         $time, m_axis_tdata[CH_W-1:0], m_axis_tdata[CH_W +: VALUE_W],
                         m_axis_tlast);
                err_count++;
            end
            else
            begin
                exp_w = chan_expect_q.pop_front();
                if (m_axis_tdata[CH_W-1:0] !== exp_w.ch_idx)
                begin
                    $display("%0t: channel index mismatch, expected %0d, actual %0d",
                             $time, exp_w.ch_idx, m_axis_tdata[CH_W-1:0]);
                    err_count++;
                end
                if (m_axis_tdata[CH_W +: VALUE_W] !== exp_w.ch_val)
                begin
                    $display("%0t: channel %0d value mismatch, expected %h, actual %h",
                             $time, exp_w.ch_idx, exp_w.ch_val,
                             m_axis_tdata[CH_W +: VALUE_W]);
                    err_count++;
                end
                if (m_axis_tlast !== exp_w.is_last)
                begin
                    $display("%0t: channel %0d last flag mismatch, expected %b, actual %b",
                             $time, exp_w.ch_idx, exp_w.is_last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge clk)
    begin : stall_watch
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_seq
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_mask();
        test_channel_masks();
        test_window_clear();
        test_rejected_windows();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (err_count == 0 && chan_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
